// File: rtl/dsec_pkg.sv
// dsec_pkg: shared types, codes and the month table for the date string converter
// used by dsec_parser, dsec_queue, dsec_convert and date_string_to_epoch_seconds
// no dependencies
package dsec_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_YEAR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TZ_OFFSET    = 1'd1;

    localparam int CFG_DATA_W = 18;
    localparam int YEAR_W     = 7;
    localparam int TZ_W       = 18;

    // job queue between parser and converter
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // ascii codes of interest
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_P    = 8'h70;
    localparam logic [7:0] CH_S    = 8'h73;

    // one converted string, as handed from the parser to the converter
    typedef struct packed {
        logic       fail;   // short string or non-digit in a required pair
        logic [6:0] mon;
        logic [6:0] day;
        logic [6:0] hr;
        logic [6:0] mn;
        logic [6:0] year;   // years since 1900, default applied
        logic       sfx_p;
        logic       sfx_s;
    } job_t;

    // days before the first of each month, february 28
    function automatic logic [8:0] cum_days(input logic [3:0] mon);
        logic [8:0] d;
        case (mon)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// File: rtl/dsec_parser.sv
// dsec_parser: front end, takes one character a word and builds a job on the last one
// depends on dsec_pkg
module dsec_parser
    import dsec_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic [7:0]        in_char,
    input  logic              in_last,
    input  logic [YEAR_W-1:0] default_year,
    output logic              job_push,
    output job_t              job
);

    typedef enum logic [7:0] {
        PH_MON       = 8'b0000_0001,
        PH_DAY       = 8'b0000_0010,
        PH_HOUR      = 8'b0000_0100,
        PH_MIN       = 8'b0000_1000,
        PH_YEAR      = 8'b0001_0000,
        PH_YEAR_DONE = 8'b0010_0000,
        PH_END_NOYR  = 8'b0100_0000,
        PH_END_YR    = 8'b1000_0000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [3:0] pend_reg, pend_next;
    logic       have_reg, have_next;
    logic       failed_reg, failed_next;
    logic       sfx_p_reg, sfx_p_next;
    logic       sfx_s_reg, sfx_s_next;
    logic [6:0] vals_reg [5];
    logic [6:0] vals_next [5];

    logic       digit;
    logic [3:0] dv;
    logic [6:0] pair_val;
    logic       year_present;

    assign digit    = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
    assign dv       = digit ? 4'(in_char - CH_ZERO) : 4'd0;
    assign pair_val = 7'(pend_reg) * 7'd10 + 7'(dv);

    // parse step for the current character
    always_comb begin
        phase_next  = phase_reg;
        pend_next   = pend_reg;
        have_next   = have_reg;
        failed_next = failed_reg;
        sfx_p_next  = sfx_p_reg;
        sfx_s_next  = sfx_s_reg;
        for (int k = 0; k < 5; k++) begin
            vals_next[k] = vals_reg[k];
        end
        unique case (phase_reg)
            PH_MON, PH_DAY, PH_HOUR, PH_MIN: begin
                if (!failed_reg) begin
                    if (!digit) begin
                        failed_next = 1'b1;
                    end else if (!have_reg) begin
                        pend_next = dv;
                        have_next = 1'b1;
                    end else begin
                        have_next = 1'b0;
                        unique case (phase_reg)
                            PH_MON: begin
                                vals_next[0] = pair_val;
                                phase_next   = PH_DAY;
                            end
                            PH_DAY: begin
                                vals_next[1] = pair_val;
                                phase_next   = PH_HOUR;
                            end
                            PH_HOUR: begin
                                vals_next[2] = pair_val;
                                phase_next   = PH_MIN;
                            end
                            default: begin
                                vals_next[3] = pair_val;
                                phase_next   = PH_YEAR;
                            end
                        endcase
                    end
                end
            end
            PH_YEAR: begin
                if (!have_reg) begin
                    if (digit) begin
                        pend_next = dv;
                        have_next = 1'b1;
                    end else begin
                        sfx_p_next = (in_char == CH_P);
                        sfx_s_next = (in_char == CH_S);
                        phase_next = PH_END_NOYR;
                    end
                end else begin
                    // a lone year digit is dropped for the default year, and the character after it is never p or s
                    if (digit) begin
                        vals_next[4] = pair_val;
                        phase_next   = PH_YEAR_DONE;
                    end else begin
                        phase_next = PH_END_NOYR;
                    end
                    have_next = 1'b0;
                end
            end
            PH_YEAR_DONE: begin
                sfx_p_next = (in_char == CH_P);
                sfx_s_next = (in_char == CH_S);
                phase_next = PH_END_YR;
            end
            default: begin
                // trailing bytes are ignored
            end
        endcase
    end

    // job for the converter, taken from the updated parse state
    assign year_present = (phase_next == PH_YEAR_DONE) || (phase_next == PH_END_YR);
    assign job_push     = in_fire && in_last;

    always_comb begin
        job.fail  = failed_next || (phase_next == PH_MON) || (phase_next == PH_DAY)
                    || (phase_next == PH_HOUR) || (phase_next == PH_MIN);
        job.mon   = vals_next[0];
        job.day   = vals_next[1];
        job.hr    = vals_next[2];
        job.mn    = vals_next[3];
        job.year  = year_present ? vals_next[4] : default_year;
        job.sfx_p = sfx_p_next;
        job.sfx_s = sfx_s_next;
    end

    // parse state, cleared after each string
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_MON;
            pend_reg   <= 4'd0;
            have_reg   <= 1'b0;
            failed_reg <= 1'b0;
            sfx_p_reg  <= 1'b0;
            sfx_s_reg  <= 1'b0;
        end else if (in_fire) begin
            if (in_last) begin
                phase_reg  <= PH_MON;
                pend_reg   <= 4'd0;
                have_reg   <= 1'b0;
                failed_reg <= 1'b0;
                sfx_p_reg  <= 1'b0;
                sfx_s_reg  <= 1'b0;
            end else begin
                phase_reg  <= phase_next;
                pend_reg   <= pend_next;
                have_reg   <= have_next;
                failed_reg <= failed_next;
                sfx_p_reg  <= sfx_p_next;
                sfx_s_reg  <= sfx_s_next;
            end
        end
    end

    // pair values, only read once their phase has passed
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            for (int k = 0; k < 5; k++) begin
                vals_reg[k] <= vals_next[k];
            end
        end
    end

endmodule

// File: rtl/dsec_queue.sv
// dsec_queue: short job queue between the parser and the converter
// depends on dsec_pkg
module dsec_queue
    import dsec_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t head
);

    job_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    logic do_push;
    logic do_pop;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/dsec_convert.sv
// dsec_convert: back end, validates a job and turns it into seconds over a few steps
// depends on dsec_pkg
module dsec_convert
    import dsec_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_empty,
    input  job_t            q_head,
    output logic            q_pop,
    input  logic [TZ_W-1:0] tz_offset,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [31:0]     m_tdata,
    output logic            m_tuser
);

    typedef enum logic [4:0] {
        CV_IDLE  = 5'b00001,
        CV_CHECK = 5'b00010,
        CV_HOURS = 5'b00100,
        CV_MINS  = 5'b01000,
        CV_SECS  = 5'b10000
    } cv_state_t;

    cv_state_t   state_reg, state_next;
    job_t        job_reg;
    logic        bad_reg;
    logic        sfx_s_reg;
    logic [15:0] days_reg;
    logic [4:0]  hr_reg;
    logic [5:0]  mn_reg;
    logic [19:0] hacc_reg;
    logic [25:0] macc_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_bad_reg;

    logic        hr24;
    logic [6:0]  hr_a;
    logic [6:0]  hr_f;
    logic [5:0]  day_a;
    logic        ok;
    logic [15:0] yr_days;
    logic        leap_add;
    logic [15:0] days_sum;
    logic [31:0] tz_add;
    logic [31:0] secs;
    logic        out_load;

    // field checks and day count
    always_comb begin
        hr24 = (job_reg.hr == 7'd24);
        hr_a = hr24 ? 7'd0 : job_reg.hr;
        hr_f = hr_a + (job_reg.sfx_p ? 7'd12 : 7'd0);
        day_a = job_reg.day[5:0] + 6'(hr24);
        ok = !job_reg.fail
             && (job_reg.mon >= 7'd1) && (job_reg.mon <= 7'd12)
             && (job_reg.day >= 7'd1) && (job_reg.day <= 7'd31)
             && (job_reg.mn <= 7'd59) && (hr_f <= 7'd23);
        // whole years from 1970, leap years every fourth
        if (job_reg.year > 7'd70) begin
            yr_days = 16'(job_reg.year - 7'd70) * 16'd365
                      + 16'((job_reg.year - 7'd69) >> 2);
        end else begin
            yr_days = 16'd0;
        end
        leap_add = (job_reg.year[1:0] == 2'd0) && (job_reg.mon >= 7'd3);
        days_sum = yr_days + 16'(cum_days(job_reg.mon[3:0])) + 16'(leap_add)
                   + 16'(day_a) - 16'd1;
    end

    assign tz_add   = sfx_s_reg ? 32'd0 : {{(32-TZ_W){tz_offset[TZ_W-1]}}, tz_offset};
    assign secs     = 32'(macc_reg) * 32'd60 + tz_add;
    assign out_load = (state_reg == CV_SECS) && (!out_valid_reg || m_tready);
    assign q_pop    = (state_reg == CV_IDLE) && !q_empty;

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CV_IDLE:  if (!q_empty) state_next = CV_CHECK;
            CV_CHECK: state_next = CV_HOURS;
            CV_HOURS: state_next = CV_MINS;
            CV_MINS:  state_next = CV_SECS;
            CV_SECS:  if (out_load) state_next = CV_IDLE;
            default:  state_next = CV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath steps: days, hours, minutes
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_head;
        end
        if (state_reg == CV_CHECK) begin
            bad_reg   <= !ok;
            sfx_s_reg <= job_reg.sfx_s;
            days_reg  <= days_sum;
            hr_reg    <= hr_f[4:0];
            mn_reg    <= job_reg.mn[5:0];
        end
        if (state_reg == CV_HOURS) begin
            hacc_reg <= 20'(days_reg) * 20'd24 + 20'(hr_reg);
        end
        if (state_reg == CV_MINS) begin
            macc_reg <= 26'(hacc_reg) * 26'd60 + 26'(mn_reg);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= bad_reg ? 32'd0 : secs;
            out_bad_reg  <= bad_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_bad_reg;

endmodule

// File: rtl/date_string_to_epoch_seconds.sv
// date_string_to_epoch_seconds: top level, date string to seconds since 1970
// depends on dsec_pkg, dsec_parser, dsec_queue, dsec_convert
//
// A string MMDDhhmm[YY][p|s] enters one character a word on the slave side,
// tlast on its final character, and one word leaves on the master side for
// each string: tuser is the bad flag and tdata the seconds since 1970
// (zero when bad). Characters are taken at one a cycle while the two-entry
// job queue has room; each finished string then passes the converter steps
// (take the job, check and count days, then the hour, minute and second
// multiply steps, the last held until the result is taken). default_year
// (index 0) and timezone_offset (index 1) go through cfg_we/cfg_index/cfg_wdata;
// the user writes them only while no string is in flight; the block does not enforce it.
module date_string_to_epoch_seconds
    import dsec_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // character stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] character
    input  logic                 s_tlast,   // last
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [31:0] seconds
    output logic                 m_tuser    // [0] bad
);

    logic [YEAR_W-1:0] default_year_reg;
    logic [TZ_W-1:0]   tz_offset_reg;
    logic              in_fire;
    logic              job_push;
    job_t              job;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    job_t              q_head;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_year_reg <= 7'd70;
            tz_offset_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DEFAULT_YEAR: default_year_reg <= cfg_wdata[YEAR_W-1:0];
                CFG_TZ_OFFSET:    tz_offset_reg    <= cfg_wdata[TZ_W-1:0];
                default: ;
            endcase
        end
    end

    // front end takes characters while the queue has room
    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    dsec_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_fire      (in_fire),
        .in_char      (s_tdata),
        .in_last      (s_tlast),
        .default_year (default_year_reg),
        .job_push     (job_push),
        .job          (job)
    );

    dsec_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    dsec_convert u_convert (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .tz_offset (tz_offset_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
